// ----- rtl/core/ihpp_pkg.sv -----
// ----------------------------------------------------------------------------
// ihpp_pkg: shared types and constants for the host:port parser
// Result status codes, character codes and the numeric limits of octets and
// ports.
// ----------------------------------------------------------------------------
package ihpp_pkg;

  typedef enum logic [1:0] {
    STATUS_NUMERIC = 2'd0,
    STATUS_HOSTNAME = 2'd1,
    STATUS_REJECT = 2'd2
  } status_t;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [11:0] OCTET_MAX = 12'd255;
  localparam logic [19:0] PORT_MAX = 20'd65535;
  localparam logic [2:0] OCTET_DIGITS_MAX = 3'd3;
  localparam logic [2:0] PORT_DIGITS_MAX = 3'd5;
  localparam logic [1:0] DOTS_MAX = 2'd3;

endpackage

// ----- rtl/core/ihpp_if.sv -----
// ----------------------------------------------------------------------------
// ihpp_if: request channels of the host:port parser
// Character channel into the parser and result channel out of it, each with
// valid/ready handshake.
// ----------------------------------------------------------------------------
interface ihpp_in_if;
  logic valid;
  logic ready;
  logic [7:0] character;
  logic final_char;

  modport source (output valid, output character, output final_char, input ready);
  modport sink (input valid, input character, input final_char, output ready);
endinterface

interface ihpp_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [31:0] address;
  logic [15:0] port_number;

  modport source (output valid, output status, output address, output port_number,
                  input ready);
  modport sink (input valid, input status, input address, input port_number,
                output ready);
endinterface

// ----- rtl/core/ipv4_host_port_parser.sv -----
// ----------------------------------------------------------------------------
// ipv4_host_port_parser: streaming "host:port" parser
// Takes one character per cycle unless stalled and gives one result per string
// on the last character: a status, the packed IPv4 address and the port.
// ----------------------------------------------------------------------------
// One character is accepted every cycle unless stalled. Each character
// updates the parse state in a single step of digit accumulate and compare;
// the result of the string is registered as its last character is accepted.
// The output register decouples the two sides, so the input stalls only
// while a finished result waits and out_ch.ready is low.
module ipv4_host_port_parser #(
  parameter int HOST_LIMIT = 64
) (
  input logic clk,
  input logic rst_n,
  ihpp_in_if.sink in_ch,
  ihpp_out_if.source out_ch
);

  localparam int HL_W = $clog2(HOST_LIMIT + 1);
  localparam logic [HL_W-1:0] HOST_LIMIT_V = HL_W'(HOST_LIMIT);

  logic in_fire;
  logic is_digit;
  logic [3:0] digit_val;

  logic in_port_r, in_port_nxt;
  logic [7:0] octet_r, octet_nxt;
  logic [2:0] octet_cnt_r, octet_cnt_nxt;
  logic [1:0] dots_r, dots_nxt;
  logic [23:0] addr_acc_r, addr_acc_nxt;
  logic all_num_r, all_num_nxt;
  logic num_err_r, num_err_nxt;
  logic [HL_W-1:0] host_len_r, host_len_nxt;
  logic [15:0] port_acc_r, port_acc_nxt;
  logic [2:0] port_cnt_r, port_cnt_nxt;
  logic port_err_r, port_err_nxt;

  logic [11:0] octet_prod;
  logic [19:0] port_prod;

  ihpp_pkg::status_t res_status;
  logic [31:0] res_address;
  logic [15:0] res_port;

  logic out_valid_r, out_valid_nxt;
  logic [1:0] out_status_r;
  logic [31:0] out_address_r;
  logic [15:0] out_port_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire = in_ch.valid && in_ch.ready;

  assign is_digit = (in_ch.character >= ihpp_pkg::CHAR_ZERO) &&
                    (in_ch.character <= ihpp_pkg::CHAR_NINE);
  assign digit_val = in_ch.character[3:0];

  assign octet_prod = {1'b0, octet_r, 3'b000} + {3'b000, octet_r, 1'b0} + {8'd0, digit_val};
  assign port_prod = {1'b0, port_acc_r, 3'b000} + {3'b000, port_acc_r, 1'b0} +
                     {16'd0, digit_val};

  always_comb begin
    in_port_nxt = in_port_r;
    octet_nxt = octet_r;
    octet_cnt_nxt = octet_cnt_r;
    dots_nxt = dots_r;
    addr_acc_nxt = addr_acc_r;
    all_num_nxt = all_num_r;
    num_err_nxt = num_err_r;
    host_len_nxt = host_len_r;
    port_acc_nxt = port_acc_r;
    port_cnt_nxt = port_cnt_r;
    port_err_nxt = port_err_r;
    if (in_fire) begin
      if (in_port_r) begin
        if (!port_err_r) begin
          if (is_digit) begin
            port_cnt_nxt = port_cnt_r + 3'd1;
            if (port_prod > ihpp_pkg::PORT_MAX || port_cnt_nxt > ihpp_pkg::PORT_DIGITS_MAX) begin
              port_err_nxt = 1'b1;
            end else begin
              port_acc_nxt = port_prod[15:0];
            end
          end else begin
            port_err_nxt = 1'b1;
          end
        end
      end else if (in_ch.character == ihpp_pkg::CHAR_COLON) begin
        in_port_nxt = 1'b1;
      end else begin
        if (host_len_r < HOST_LIMIT_V) begin
          host_len_nxt = host_len_r + HL_W'(1);
        end
        if (is_digit) begin
          if (!num_err_r) begin
            octet_cnt_nxt = octet_cnt_r + 3'd1;
            if (octet_prod > ihpp_pkg::OCTET_MAX ||
                octet_cnt_nxt > ihpp_pkg::OCTET_DIGITS_MAX) begin
              num_err_nxt = 1'b1;
            end else begin
              octet_nxt = octet_prod[7:0];
            end
          end
        end else if (in_ch.character == ihpp_pkg::CHAR_DOT) begin
          if (!num_err_r) begin
            if (octet_cnt_r == 3'd0 || dots_r >= ihpp_pkg::DOTS_MAX) begin
              num_err_nxt = 1'b1;
            end else begin
              addr_acc_nxt = {addr_acc_r[15:0], octet_r};
              dots_nxt = dots_r + 2'd1;
              octet_nxt = 8'd0;
              octet_cnt_nxt = 3'd0;
            end
          end
        end else begin
          all_num_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    res_address = 32'd0;
    res_port = 16'd0;
    if (!in_port_nxt || port_err_nxt || port_cnt_nxt == 3'd0 || port_acc_nxt == 16'd0) begin
      res_status = ihpp_pkg::STATUS_REJECT;
    end else if (host_len_nxt >= HOST_LIMIT_V) begin
      res_status = ihpp_pkg::STATUS_REJECT;
    end else if (host_len_nxt == HL_W'(0) || !all_num_nxt) begin
      res_status = ihpp_pkg::STATUS_HOSTNAME;
    end else if (num_err_nxt || dots_nxt != ihpp_pkg::DOTS_MAX || octet_cnt_nxt == 3'd0) begin
      res_status = ihpp_pkg::STATUS_REJECT;
    end else begin
      res_status = ihpp_pkg::STATUS_NUMERIC;
      res_address = {addr_acc_nxt, octet_nxt};
    end
    if (res_status != ihpp_pkg::STATUS_REJECT) begin
      res_port = port_acc_nxt;
    end
  end

  assign out_valid_nxt = (in_fire && in_ch.final_char) || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_ch.final_char)) begin
      in_port_r <= 1'b0;
      octet_r <= 8'd0;
      octet_cnt_r <= 3'd0;
      dots_r <= 2'd0;
      addr_acc_r <= 24'd0;
      all_num_r <= 1'b1;
      num_err_r <= 1'b0;
      host_len_r <= HL_W'(0);
      port_acc_r <= 16'd0;
      port_cnt_r <= 3'd0;
      port_err_r <= 1'b0;
    end else begin
      in_port_r <= in_port_nxt;
      octet_r <= octet_nxt;
      octet_cnt_r <= octet_cnt_nxt;
      dots_r <= dots_nxt;
      addr_acc_r <= addr_acc_nxt;
      all_num_r <= all_num_nxt;
      num_err_r <= num_err_nxt;
      host_len_r <= host_len_nxt;
      port_acc_r <= port_acc_nxt;
      port_cnt_r <= port_cnt_nxt;
      port_err_r <= port_err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_ch.final_char) begin
      out_status_r <= res_status;
      out_address_r <= res_address;
      out_port_r <= res_port;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.address = out_address_r;
  assign out_ch.port_number = out_port_r;

endmodule

// ----- rtl/core/ihpp_checker.sv -----
// ----------------------------------------------------------------------------
// ihpp_checker: port-level checks for the host:port parser
// Watches the request channels and the result fields over time.
// ----------------------------------------------------------------------------
module ihpp_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_final_char,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] out_status,
  input logic [31:0] out_address,
  input logic [15:0] out_port_number
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_address) && $stable(out_port_number))
    else $error("result changed while stalled");

  a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_final_char |=> out_valid)
    else $error("no result after last character");

  a_addr_only_numeric: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ihpp_pkg::STATUS_NUMERIC |-> out_address == 32'd0)
    else $error("address set on non-numeric result");

  a_reject_no_port: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ihpp_pkg::STATUS_REJECT |-> out_port_number == 16'd0)
    else $error("port set on rejected result");

  a_accept_port_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ihpp_pkg::STATUS_REJECT |-> out_port_number != 16'd0)
    else $error("accepted result with port zero");

endmodule

bind ipv4_host_port_parser ihpp_checker u_ihpp_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .in_final_char(in_ch.final_char),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_status(out_ch.status),
  .out_address(out_ch.address),
  .out_port_number(out_ch.port_number)
);
